FILE: sv/ttf_pkg.sv
// ----------------------------------------------------------------------------
// ttf_pkg
// Shared widths, types and defaults of the triangle tangent frame block.
// ----------------------------------------------------------------------------
package ttf_pkg;

  localparam int COORD_W           = 32;  // input coordinates
  localparam int DIFF_W            = 33;  // edge and texture deltas
  localparam int PROD_W            = 66;  // one delta product
  localparam int VEC_W             = 67;  // difference of two products
  localparam int OUT_W             = 16;  // output component
  localparam int OUT_FRAC_BITS_DEF = 14;
  localparam int SCALE_W           = 31;  // scaled magnitude lands in [2^30, 2^31)
  localparam int SUM_W             = 64;  // sum of squares
  localparam int ROOT_W            = 32;  // integer square root
  localparam int SAT_MAX           = 32767;
  localparam int NUM_PAIRS         = 7;   // det, three tangent, three bitangent

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [VEC_W-1:0]   vec_t;
  typedef logic signed [OUT_W-1:0]   comp_t;

endpackage

FILE: sv/ttf_normalize.sv
// ----------------------------------------------------------------------------
// ttf_normalize
// Iterative unit-length normalization of one wide signed 3-vector.
// ----------------------------------------------------------------------------
module ttf_normalize #(
  parameter int OUT_FRAC_BITS = ttf_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  ttf_pkg::vec_t  vec_in [3],
  output logic           done,
  output ttf_pkg::comp_t res_out [3]
);
  import ttf_pkg::*;

  localparam int NUM_W  = SCALE_W + OUT_FRAC_BITS + 1;
  localparam int DCNT_W = $clog2(NUM_W + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SCALE, S_SQ, S_ROOT, S_LOAD, S_DIV, S_STORE
  } state_t;

  state_t               state_r;
  logic                 done_r;
  logic                 sgn_r [3];
  logic [VEC_W-1:0]     mag_r [3];
  logic [1:0]           idx_r;
  logic [2*SCALE_W-1:0] sq_r;
  logic [SUM_W-1:0]     sum_r;
  logic [SUM_W-1:0]     rem_r;
  logic [SUM_W-1:0]     root_r;
  logic [SUM_W-1:0]     bit_r;
  logic [NUM_W-1:0]     num_r;
  logic [NUM_W-1:0]     quo_r;
  logic [ROOT_W-1:0]    drem_r;
  logic [DCNT_W-1:0]    dcnt_r;
  comp_t                res_r [3];

  logic [VEC_W-1:0]   mag_or;
  logic [SCALE_W-1:0] sel_mag;
  logic               sel_sgn;
  logic [SUM_W-1:0]   root_try;
  logic               root_ge;
  logic [ROOT_W-1:0]  root_n;
  logic [ROOT_W:0]    div_try;
  logic               div_ge;
  logic [ROOT_W:0]    div_sub;
  logic [OUT_W-1:0]   q_mag;

  // OR of all three magnitudes: its leading bit is that of the largest
  assign mag_or = mag_r[0] | mag_r[1] | mag_r[2];

  // component select for squaring and division
  always_comb begin
    unique case (idx_r)
      2'd0:    begin sel_mag = mag_r[0][SCALE_W-1:0]; sel_sgn = sgn_r[0]; end
      2'd1:    begin sel_mag = mag_r[1][SCALE_W-1:0]; sel_sgn = sgn_r[1]; end
      2'd2:    begin sel_mag = mag_r[2][SCALE_W-1:0]; sel_sgn = sgn_r[2]; end
      default: begin sel_mag = '0;                    sel_sgn = 1'b0;     end
    endcase
  end

  // square root step
  assign root_try = root_r + bit_r;
  assign root_ge  = (rem_r >= root_try);
  assign root_n   = root_r[ROOT_W-1:0];

  // restoring divide step
  assign div_try = {drem_r, num_r[NUM_W-1]};
  assign div_ge  = (div_try >= {1'b0, root_n});
  assign div_sub = div_try - {1'b0, root_n};

  // saturate quotient
  assign q_mag = (quo_r > NUM_W'(SAT_MAX)) ? OUT_W'(SAT_MAX) : quo_r[OUT_W-1:0];

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          done_r <= 1'b0;
          if (start) begin
            for (int i = 0; i < 3; i++) begin
              sgn_r[i] <= vec_in[i][VEC_W-1];
              mag_r[i] <= vec_in[i][VEC_W-1] ? VEC_W'(-vec_in[i]) : VEC_W'(vec_in[i]);
            end
            state_r <= S_SCALE;
          end
        end
        // one bit of shift per cycle until the largest lands in [2^30, 2^31)
        S_SCALE: begin
          if (|mag_or[VEC_W-1:SCALE_W]) begin
            for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 1;
          end else if (!mag_or[SCALE_W-1]) begin
            for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] << 1;
          end else begin
            idx_r   <= '0;
            sum_r   <= '0;
            state_r <= S_SQ;
          end
        end
        // square into a register, then accumulate it in the following cycle
        S_SQ: begin
          sq_r <= sel_mag * sel_mag;
          if (idx_r != 2'd0) sum_r <= sum_r + SUM_W'(sq_r);
          if (idx_r == 2'd3) begin
            rem_r   <= sum_r + SUM_W'(sq_r);
            root_r  <= '0;
            bit_r   <= SUM_W'(1) << (SUM_W - 2);
            state_r <= S_ROOT;
          end else begin
            idx_r <= idx_r + 2'd1;
          end
        end
        // two bits of the radicand per cycle
        S_ROOT: begin
          if (root_ge) begin
            rem_r  <= rem_r - root_try;
            root_r <= (root_r >> 1) + bit_r;
          end else begin
            root_r <= root_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (bit_r[0]) begin
            idx_r   <= '0;
            state_r <= S_LOAD;
          end
        end
        // rounded numerator for one component
        S_LOAD: begin
          num_r   <= NUM_W'({sel_mag, {OUT_FRAC_BITS{1'b0}}}) + NUM_W'(root_n >> 1);
          quo_r   <= '0;
          drem_r  <= '0;
          dcnt_r  <= '0;
          state_r <= S_DIV;
        end
        // one quotient bit per cycle
        S_DIV: begin
          drem_r <= div_ge ? div_sub[ROOT_W-1:0] : div_try[ROOT_W-1:0];
          quo_r  <= {quo_r[NUM_W-2:0], div_ge};
          num_r  <= num_r << 1;
          dcnt_r <= dcnt_r + DCNT_W'(1);
          if (dcnt_r == DCNT_W'(NUM_W - 1)) state_r <= S_STORE;
        end
        S_STORE: begin
          res_r[idx_r] <= sel_sgn ? comp_t'(-q_mag) : comp_t'(q_mag);
          if (idx_r == 2'd2) begin
            done_r  <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            idx_r   <= idx_r + 2'd1;
            state_r <= S_LOAD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign done    = done_r;
  assign res_out = res_r;

endmodule

FILE: sv/triangle_tangent_frame.sv
// ----------------------------------------------------------------------------
// triangle_tangent_frame
// Unit tangent and bitangent of a textured triangle from three corners.
// ----------------------------------------------------------------------------
// Corners arrive one request each, in index order; the first two are taken as
// they arrive and held. The third corner starts the frame computation and
// in_stall stays high until the result is loaded into the output register:
// one shared 33x33 multiplier forms the determinant and the six vector
// components, a sign fix and degenerate check follows, then two passes of the
// iterative normalizer (magnitude scaling one bit per cycle, square root two
// bits per cycle, division one bit per cycle). The output is Q2.14 by default;
// a degenerate triangle skips the normalizer. A waiting result does not block
// the next two corners.
module triangle_tangent_frame #(
  parameter int OUT_FRAC_BITS = ttf_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  ttf_pkg::coord_t in_pos_x,
  input  ttf_pkg::coord_t in_pos_y,
  input  ttf_pkg::coord_t in_pos_z,
  input  ttf_pkg::coord_t in_tex_u,
  input  ttf_pkg::coord_t in_tex_v,
  output logic            out_valid,
  input  logic            out_stall,
  output ttf_pkg::comp_t  out_tangent_x,
  output ttf_pkg::comp_t  out_tangent_y,
  output ttf_pkg::comp_t  out_tangent_z,
  output ttf_pkg::comp_t  out_bitangent_x,
  output ttf_pkg::comp_t  out_bitangent_y,
  output ttf_pkg::comp_t  out_bitangent_z,
  output logic            out_degenerate
);
  import ttf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_ACC, ST_FIX, ST_NORM_T, ST_NORM_B, ST_DONE
  } state_t;

  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  state_t      state_r;
  logic [1:0]  cnt_r;
  coord_t      pos_r [2][3];
  coord_t      uv_r  [2][2];
  diff_t       e1_r [3];
  diff_t       e2_r [3];
  diff_t       du1_r, dv1_r, du2_r, dv2_r;
  logic [2:0]  pair_r;
  logic        half_r;
  prod_t       prod_r;
  prod_t       acc_r;
  vec_t        vec_r [NUM_PAIRS];
  logic        degen_r;
  logic        norm_start_r;
  comp_t       tan_r [3];
  comp_t       bitan_r [3];
  logic        out_valid_r;
  comp_t       out_tan_r [3];
  comp_t       out_bit_r [3];
  logic        out_degen_r;

  coord_t      in_pos [3];
  logic [1:0]  ci;
  diff_t       op_a, op_b;
  vec_t        norm_vec [3];
  logic        norm_done;
  comp_t       norm_res [3];
  logic        det_neg;
  logic        degen;

  assign in_pos = '{in_pos_x, in_pos_y, in_pos_z};

  // component index of the current product pair
  always_comb begin
    unique case (pair_r)
      3'd1, 3'd4: ci = 2'd0;
      3'd2, 3'd5: ci = 2'd1;
      3'd3, 3'd6: ci = 2'd2;
      default:    ci = 2'd0;
    endcase
  end

  // multiplier operands: each pair is first product minus second
  always_comb begin
    unique case (pair_r)
      3'd0: begin
        op_a = half_r ? du2_r : du1_r;
        op_b = half_r ? dv1_r : dv2_r;
      end
      3'd1, 3'd2, 3'd3: begin
        op_a = half_r ? e2_r[ci] : e1_r[ci];
        op_b = half_r ? dv1_r : dv2_r;
      end
      3'd4, 3'd5, 3'd6: begin
        op_a = half_r ? e1_r[ci] : e2_r[ci];
        op_b = half_r ? du2_r : du1_r;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // determinant sign and degenerate check
  assign det_neg = vec_r[0][VEC_W-1];
  assign degen   = (vec_r[0] == '0)
                || ((vec_r[1] | vec_r[2] | vec_r[3]) == '0)
                || ((vec_r[4] | vec_r[5] | vec_r[6]) == '0);

  // normalizer input: tangent first, then bitangent
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      norm_vec[i] = (state_r == ST_NORM_B) ? vec_r[4 + i] : vec_r[1 + i];
    end
  end

  ttf_normalize #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_norm (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (norm_start_r),
    .vec_in  (norm_vec),
    .done    (norm_done),
    .res_out (norm_res)
  );

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      norm_start_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      // result leaves on an accepted request; ST_DONE reloads it below
      if (out_valid_r && !out_stall && state_r != ST_DONE) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            if (cnt_r < 2'd2) begin
              // hold corner 0 or 1
              pos_r[cnt_r[0]] <= in_pos;
              uv_r[cnt_r[0]]  <= '{in_tex_u, in_tex_v};
              cnt_r           <= cnt_r + 2'd1;
            end else begin
              // third corner: edges and texture deltas
              for (int i = 0; i < 3; i++) begin
                e1_r[i] <= diff_t'(pos_r[1][i]) - diff_t'(pos_r[0][i]);
                e2_r[i] <= diff_t'(in_pos[i]) - diff_t'(pos_r[0][i]);
              end
              du1_r   <= diff_t'(uv_r[1][0]) - diff_t'(uv_r[0][0]);
              dv1_r   <= diff_t'(uv_r[1][1]) - diff_t'(uv_r[0][1]);
              du2_r   <= diff_t'(in_tex_u) - diff_t'(uv_r[0][0]);
              dv2_r   <= diff_t'(in_tex_v) - diff_t'(uv_r[0][1]);
              cnt_r   <= '0;
              pair_r  <= '0;
              half_r  <= 1'b0;
              state_r <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          prod_r  <= op_a * op_b;
          state_r <= ST_ACC;
        end
        ST_ACC: begin
          if (!half_r) begin
            acc_r  <= prod_r;
            half_r <= 1'b1;
          end else begin
            vec_r[pair_r] <= vec_t'(acc_r) - vec_t'(prod_r);
            half_r        <= 1'b0;
            pair_r        <= pair_r + 3'd1;
          end
          state_r <= (half_r && pair_r == 3'(NUM_PAIRS - 1)) ? ST_FIX : ST_MUL;
        end
        ST_FIX: begin
          for (int i = 1; i < NUM_PAIRS; i++) begin
            vec_r[i] <= det_neg ? -vec_r[i] : vec_r[i];
          end
          degen_r      <= degen;
          norm_start_r <= !degen;
          if (degen) begin
            state_r <= ST_DONE;
          end else begin
            state_r <= ST_NORM_T;
          end
        end
        ST_NORM_T: begin
          norm_start_r <= norm_done;
          if (norm_done) begin
            tan_r   <= norm_res;
            state_r <= ST_NORM_B;
          end
        end
        ST_NORM_B: begin
          norm_start_r <= 1'b0;
          if (norm_done) begin
            bitan_r <= norm_res;
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          // load once the output register is free
          if (!out_valid_r || !out_stall) begin
            for (int i = 0; i < 3; i++) begin
              out_tan_r[i] <= degen_r ? '0 : tan_r[i];
              out_bit_r[i] <= degen_r ? '0 : bitan_r[i];
            end
            out_degen_r <= degen_r;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_tangent_x   = out_tan_r[0];
  assign out_tangent_y   = out_tan_r[1];
  assign out_tangent_z   = out_tan_r[2];
  assign out_bitangent_x = out_bit_r[0];
  assign out_bitangent_y = out_bit_r[1];
  assign out_bitangent_z = out_bit_r[2];
  assign out_degenerate  = out_degen_r;

endmodule
